@@ hdl/pec_pkg.sv @@
// pec_pkg: shared types and constants for the prime exponent counter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pec_pkg;

	// default width of the number to factorize
	localparam int NUMBER_BITS_DEF = 20;

	// result field widths
	localparam int TOTAL_W    = 5;
	localparam int DISTINCT_W = 4;
	localparam int ANSWER_W   = 6;

	// internal count width, holds up to 63 factors; the output saturates at 31
	localparam int CNT_W = 6;

	// saturation limits
	localparam logic [CNT_W-1:0]    TOTAL_MAX  = 6'd31;
	localparam logic [ANSWER_W-1:0] ANSWER_MAX = 6'd31;

	// working record in the scratch memory
	localparam int   REC_DEPTH = 2;
	localparam logic REC_N     = 1'b0;  // remaining cofactor
	localparam logic REC_D     = 1'b1;  // current trial divisor

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_RD_N,
		ST_RD_D,
		ST_LOAD,
		ST_CHK,
		ST_DIV,
		ST_FIN
	} pec_state_t;

endpackage

`default_nettype wire

@@ hdl/prime_exponent_counter.sv @@
// prime_exponent_counter: one number at a time, trial division over 2 and the odd divisors;
// each trial passes ST_RD_N, ST_RD_D, ST_LOAD and ST_CHK to read the scratch ram and check,
// then runs the bit-serial divider, and a factor hit costs one more trial with the same
// divisor; busy falls as done rises, so the next word can go in at the edge that takes
// the result word; the receiver cannot stall; arst_n clears the control state
`timescale 1ns / 1ps
`default_nettype none

module prime_exponent_counter
	import pec_pkg::*;
#(
	parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [NUMBER_BITS-1:0]     number,
	output logic                            done,
	output logic      [TOTAL_W-1:0]         total_exponents,
	output logic      [DISTINCT_W-1:0]      distinct_primes,
	output logic signed [ANSWER_W-1:0]      answer
);

	// square of the trial divisor needs two bits above the number width
	localparam int SW = NUMBER_BITS + 2;

	pec_state_t state_q, state_d;

	// working registers; n_q and d_q are loaded from the scratch ram each trial
	logic [NUMBER_BITS-1:0] n_q;
	logic [NUMBER_BITS-1:0] d_q;
	logic [SW-1:0]          sq_q;
	logic [CNT_W-1:0]       total_q;
	logic [DISTINCT_W-1:0]  distinct_q;
	logic                   hit_q;      // current divisor already counted as distinct

	// output word register
	logic                   done_q;
	logic [TOTAL_W-1:0]     total_out_q;
	logic [DISTINCT_W-1:0]  distinct_out_q;
	logic [ANSWER_W-1:0]    answer_out_q;

	// scratch ram port
	logic                   ram_we;
	logic                   ram_waddr;
	logic [NUMBER_BITS-1:0] ram_wdata;
	logic                   ram_raddr;
	logic [NUMBER_BITS-1:0] ram_rdata;

	// divider port
	logic                   div_start;
	logic                   div_done;
	logic [NUMBER_BITS-1:0] div_quo;
	logic                   div_rem_zero;

	// next divisor and its square: 2 -> 3, then odd steps of two
	logic                   d_is_two;
	logic [NUMBER_BITS-1:0] d_next;
	logic [SW-1:0]          sq_next;
	logic                   n_gt_one;
	logic                   keep_trying;

	// final counts including a leftover prime cofactor
	logic [CNT_W-1:0]       fin_total;
	logic [DISTINCT_W-1:0]  fin_dist;
	logic [CNT_W:0]         fin_sum;
	logic [TOTAL_W-1:0]     fin_total_sat;
	logic [ANSWER_W-1:0]    fin_answer;

	assign d_is_two = (d_q == NUMBER_BITS'(2));
	assign d_next   = d_q + (d_is_two ? NUMBER_BITS'(1) : NUMBER_BITS'(2));
	assign sq_next  = d_is_two ? (sq_q + SW'(5))
	                           : (sq_q + {d_q, 2'b00} + SW'(4));
	assign n_gt_one = (n_q > NUMBER_BITS'(1));

	// after a hit the same divisor is tried again without the square test
	assign keep_trying = hit_q || (n_gt_one && (sq_q <= {2'b00, n_q}));

	assign fin_total     = total_q + CNT_W'(n_gt_one);
	assign fin_dist      = distinct_q + DISTINCT_W'(n_gt_one);
	assign fin_sum       = {1'b0, fin_total} + (CNT_W + 1)'(fin_dist);
	assign fin_total_sat = (fin_total > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0]
	                                               : fin_total[TOTAL_W-1:0];
	// sum minus one, saturated; zero sum wraps to all ones, which is -1
	assign fin_answer    = (fin_sum > (CNT_W + 1)'(32)) ? ANSWER_MAX
	                       : ANSWER_W'(fin_sum - (CNT_W + 1)'(1));

	pec_ram #(
		.WIDTH (NUMBER_BITS),
		.DEPTH (REC_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pec_div #(
		.NUMBER_BITS (NUMBER_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n_q),
		.divisor  (d_q),
		.done     (div_done),
		.quotient (div_quo),
		.rem_zero (div_rem_zero)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, ram and divider control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = REC_N;
		ram_wdata = '0;
		ram_raddr = REC_N;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					// store the incoming word as the cofactor
					ram_we    = 1'b1;
					ram_waddr = REC_N;
					ram_wdata = number;
					state_d   = ST_INIT;
				end
			end
			ST_INIT: begin
				// first trial divisor is two
				ram_we    = 1'b1;
				ram_waddr = REC_D;
				ram_wdata = NUMBER_BITS'(2);
				state_d   = ST_RD_N;
			end
			ST_RD_N: begin
				ram_raddr = REC_N;
				state_d   = ST_RD_D;
			end
			ST_RD_D: begin
				ram_raddr = REC_D;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (keep_trying) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					ram_we = 1'b1;
					if (div_rem_zero) begin
						// divisor hit: write back the quotient
						ram_waddr = REC_N;
						ram_wdata = div_quo;
					end else begin
						// miss: move on to the next divisor
						ram_waddr = REC_D;
						ram_wdata = d_next;
					end
					state_d = ST_RD_N;
				end
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				total_q    <= '0;
				distinct_q <= '0;
				hit_q      <= 1'b0;
				sq_q       <= SW'(4);
			end
			ST_RD_D: begin
				n_q <= ram_rdata;
			end
			ST_LOAD: begin
				d_q <= ram_rdata;
			end
			ST_DIV: begin
				if (div_done) begin
					if (div_rem_zero) begin
						total_q <= total_q + 1'b1;
						hit_q   <= 1'b1;
						if (!hit_q) begin
							distinct_q <= distinct_q + 1'b1;
						end
					end else begin
						hit_q <= 1'b0;
						sq_q  <= sq_next;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result word, shown for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FIN);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			total_out_q    <= fin_total_sat;
			distinct_out_q <= fin_dist;
			answer_out_q   <= fin_answer;
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign total_exponents = total_out_q;
	assign distinct_primes = distinct_out_q;
	assign answer          = answer_out_q;

`ifndef SYNTHESIS
	// the result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// an accepted word makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	// the divider only finishes while the controller waits for it
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// a result word comes only at the end of a factorization
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_FIN))
		else $error("result word without a finished factorization");
`endif

endmodule

`default_nettype wire

@@ hdl/pec_ram.sv @@
// pec_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ hdl/pec_div.sv @@
// pec_div: restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pec_div #(
	parameter int NUMBER_BITS = 20
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [NUMBER_BITS-1:0] dividend,
	input  wire logic [NUMBER_BITS-1:0] divisor,
	output logic                        done,
	output logic      [NUMBER_BITS-1:0] quotient,
	output logic                        rem_zero
);

	localparam int CW = $clog2(NUMBER_BITS + 1);

	logic                   run_q;
	logic [CW-1:0]          cnt_q;
	logic [NUMBER_BITS-1:0] quo_q;
	logic [NUMBER_BITS-1:0] rem_q;
	logic [NUMBER_BITS-1:0] dvs_q;
	logic                   done_q;
	logic [NUMBER_BITS:0]   trial;
	logic [NUMBER_BITS:0]   diff;
	logic                   fits;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[NUMBER_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NUMBER_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? diff[NUMBER_BITS-1:0] : trial[NUMBER_BITS-1:0];
			quo_q <= {quo_q[NUMBER_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
	assign rem_zero = (rem_q == '0);

endmodule

`default_nettype wire
